FILE: rtl/core/pfe_pkg.sv
// pfe_pkg: shared types, character codes and the hex glyph function
// for the printf format engine; no dependencies
package pfe_pkg;

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [63:0] arg_value;
    } pfe_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } pfe_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } pfe_state_t;

    localparam int BIN_W   = 32;
    localparam int BCD_DIG = 10;
    localparam int BCD_W   = BCD_DIG * 4;
    localparam int DIG_W   = 64;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_C = 8'h63;

    // "0123456789ABCDEF"
    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        logic [7:0] g;
        if (nib < 4'd10) begin
            g = CH_ZERO + {4'b0, nib};
        end else begin
            g = 8'h37 + {4'b0, nib};
        end
        return g;
    endfunction

endpackage

FILE: rtl/core/pfe_bcd.sv
// pfe_bcd: bit-serial binary to BCD converter (shift and add-3), one bit per cycle
// depends on pfe_pkg
module pfe_bcd
    import pfe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [BIN_W-1:0] bin_value,
    output logic             done,
    output logic [BCD_W-1:0] bcd_digits
);

    logic [BIN_W-1:0]         bin_reg, bin_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [$clog2(BIN_W)-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [BCD_W-1:0]         adj;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = bin_value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(BIN_W))'(BIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    assign done       = done_reg;
    assign bcd_digits = bcd_reg;

endmodule

FILE: rtl/core/pfe_fmt.sv
// pfe_fmt: format byte decoder and character sequencer with output register
// depends on pfe_pkg; drives the pfe_bcd converter
module pfe_fmt
    import pfe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pfe_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pfe_out_t         m_data,
    output logic             bcd_start,
    output logic [BIN_W-1:0] bcd_value,
    input  logic             bcd_done,
    input  logic [BCD_W-1:0] bcd_digits
);

    pfe_state_t       state_reg, state_next;
    logic             pending_reg, pending_next;
    logic [1:0]       pfx_cnt_reg, pfx_cnt_next;
    logic [7:0]       pfx0_reg, pfx0_next;
    logic [7:0]       pfx1_reg, pfx1_next;
    logic [DIG_W-1:0] dig_reg, dig_next;
    logic [4:0]       dig_cnt_reg, dig_cnt_next;
    logic             skip_reg, skip_next;
    logic             m_valid_reg, m_valid_next;
    pfe_out_t         m_data_reg, m_data_next;

    logic             slot_free;
    logic [BIN_W-1:0] low_word;
    logic [3:0]       top_nib;

    assign slot_free = !m_valid_reg || m_ready;
    assign low_word  = s_data.arg_value[BIN_W-1:0];
    assign top_nib   = dig_reg[DIG_W-1 -: 4];
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        pfx_cnt_next = pfx_cnt_reg;
        pfx0_next    = pfx0_reg;
        pfx1_next    = pfx1_reg;
        dig_next     = dig_reg;
        dig_cnt_next = dig_cnt_reg;
        skip_next    = skip_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        bcd_start    = 1'b0;
        bcd_value    = low_word;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dig_cnt_next = 5'd0;
                    skip_next    = 1'b0;
                    if (s_data.fmt_char == CH_NUL) begin
                        pending_next = 1'b0;
                    end else if (!pending_reg) begin
                        if (s_data.fmt_char == CH_PERCENT) begin
                            pending_next = 1'b1;
                        end else begin
                            pfx0_next    = s_data.fmt_char;
                            pfx_cnt_next = 2'd1;
                            state_next   = ST_EMIT;
                        end
                    end else begin
                        pending_next = 1'b0;
                        case (s_data.fmt_char)
                            CH_LOWER_D: begin
                                bcd_start    = 1'b1;
                                bcd_value    = low_word[BIN_W-1] ? (BIN_W'(0) - low_word)
                                                                 : low_word;
                                pfx0_next    = CH_MINUS;
                                pfx_cnt_next = {1'b0, low_word[BIN_W-1]};
                                skip_next    = 1'b1;
                                state_next   = ST_CONV;
                            end
                            CH_LOWER_L: begin
                                bcd_start    = 1'b1;
                                pfx_cnt_next = 2'd0;
                                skip_next    = 1'b1;
                                state_next   = ST_CONV;
                            end
                            CH_LOWER_X: begin
                                dig_next     = {low_word, {(DIG_W-BIN_W){1'b0}}};
                                dig_cnt_next = 5'(BIN_W / 4);
                                pfx_cnt_next = 2'd0;
                                skip_next    = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            CH_LOWER_P: begin
                                dig_next     = s_data.arg_value;
                                dig_cnt_next = 5'(DIG_W / 4);
                                pfx0_next    = CH_ZERO;
                                pfx1_next    = CH_LOWER_X;
                                pfx_cnt_next = 2'd2;
                                state_next   = ST_EMIT;
                            end
                            CH_LOWER_C: begin
                                pfx0_next    = s_data.arg_value[7:0];
                                pfx_cnt_next = 2'd1;
                                state_next   = ST_EMIT;
                            end
                            CH_PERCENT: begin
                                pfx0_next    = CH_PERCENT;
                                pfx_cnt_next = 2'd1;
                                state_next   = ST_EMIT;
                            end
                            default: begin
                                pfx0_next    = CH_PERCENT;
                                pfx1_next    = s_data.fmt_char;
                                pfx_cnt_next = 2'd2;
                                state_next   = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    dig_next     = {bcd_digits, {(DIG_W-BCD_W){1'b0}}};
                    dig_cnt_next = 5'(BCD_DIG);
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (pfx_cnt_reg != 2'd0) begin
                    if (slot_free) begin
                        m_valid_next            = 1'b1;
                        m_data_next.out_char    = pfx0_reg;
                        m_data_next.last_of_run = (pfx_cnt_reg == 2'd1) && (dig_cnt_reg == 5'd0);
                        pfx0_next               = pfx1_reg;
                        pfx_cnt_next            = pfx_cnt_reg - 2'd1;
                        if (m_data_next.last_of_run) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (skip_reg && top_nib == 4'd0 && dig_cnt_reg > 5'd1) begin
                    // drop a leading zero, no transfer
                    dig_next     = {dig_reg[DIG_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 5'd1;
                end else if (slot_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.out_char    = hex_glyph(top_nib);
                    m_data_next.last_of_run = (dig_cnt_reg == 5'd1);
                    dig_next                = {dig_reg[DIG_W-5:0], 4'd0};
                    dig_cnt_next            = dig_cnt_reg - 5'd1;
                    skip_next               = 1'b0;
                    if (dig_cnt_reg == 5'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
        pfx_cnt_reg <= pfx_cnt_next;
        pfx0_reg    <= pfx0_next;
        pfx1_reg    <= pfx1_next;
        dig_reg     <= dig_next;
        dig_cnt_reg <= dig_cnt_next;
        skip_reg    <= skip_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/printf_format_engine_top.sv
// printf_format_engine_top: printf-style format byte interpreter
// depends on pfe_pkg, pfe_fmt and pfe_bcd
//
// Usage: one format byte with its argument arrives per transfer on the s_
// channel (s_data.fmt_char, s_data.arg_value). The m_ channel returns the
// ASCII characters that byte produces, one per transfer; m_data.last_of_run
// marks the final character of a run. A '%' or a zero byte gives no output.
// Timing: one item is in work at a time; s_ready is high while idle.
// A plain byte or a one/two-character conversion is decoded, then emitted one
// character per transfer. Hex 'x' drops leading zero nibbles without a
// transfer; 'p' is 18 characters. Decimal 'd' and 'l' run the bit-serial BCD
// converter (one input bit per cycle), then emit the digits, dropping leading
// zeros without a transfer.
// A finished character waits in the output register, so the next item is
// taken while the last character of a run is still unclaimed. A stalled
// m_ready simply holds the sequencer. Reset (aresetn low, synchronous)
// clears the pending '%' flag and returns the block to idle with m_valid low.
module printf_format_engine_top
    import pfe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pfe_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfe_out_t m_data
);

    logic             bcd_start;
    logic [BIN_W-1:0] bcd_value;
    logic             bcd_done;
    logic [BCD_W-1:0] bcd_digits;

    pfe_fmt u_fmt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .bcd_start  (bcd_start),
        .bcd_value  (bcd_value),
        .bcd_done   (bcd_done),
        .bcd_digits (bcd_digits)
    );

    pfe_bcd u_bcd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (bcd_start),
        .bin_value  (bcd_value),
        .done       (bcd_done),
        .bcd_digits (bcd_digits)
    );

endmodule
